// File: hdl/cts_pkg.sv
`default_nettype none
package cts_pkg;

	localparam int DATA_W        = 32;
	localparam int ROW_W         = 6;
	localparam int MAX_ROWS_DEF  = 64;
	localparam int FRAC_BITS_DEF = 24;

	// complex fixed-point value
	typedef struct packed {
		logic signed [DATA_W-1:0] re;
		logic signed [DATA_W-1:0] im;
	} cplx_t;

	typedef enum logic {
		OP_MUL = 1'b0,
		OP_DIV = 1'b1
	} op_t;

	// request to the shared arithmetic unit
	typedef struct packed {
		logic  go;
		op_t   op;
		cplx_t x;
		cplx_t y;
	} alu_req_t;

	// status back from the shared arithmetic unit
	typedef struct packed {
		logic idle;
		logic done;
		logic dz;
	} alu_stat_t;

endpackage
`default_nettype wire

// File: hdl/cts_ram.sv
`default_nettype none
module cts_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// File: hdl/cts_alu.sv
`default_nettype none
module cts_alu import cts_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire alu_req_t  req,
	output cplx_t          z,
	output alu_stat_t      stat
);

	localparam int DIV_STEPS = 64 + FRAC_BITS;
	localparam int CNT_W     = $clog2(DIV_STEPS);
	localparam logic [33:0] QCAP = 34'h200000000;

	typedef enum logic [6:0] {
		A_IDLE = 7'b0000001,
		A_MUL  = 7'b0000010,
		A_ACC  = 7'b0000100,
		A_RND  = 7'b0001000,
		A_DCHK = 7'b0010000,
		A_DIV  = 7'b0100000,
		A_FIN  = 7'b1000000
	} astate_t;

	astate_t                  state_q;
	op_t                      op_q;
	cplx_t                    x_q, y_q, z_q;
	logic [2:0]               k_q;
	logic signed [63:0]       prod_s1;
	logic signed [64:0]       acc_a_q, acc_b_q, acc_c_q, acc_n;
	logic [DIV_STEPS-1:0]     dvd_q;
	logic [63:0]              rem_q;
	logic [33:0]              q_q, q_cap;
	logic [CNT_W-1:0]         cnt_q;
	logic                     part_q, dz_q;
	logic signed [DATA_W-1:0] opa, opb;
	logic                     acc_sub;
	logic [64:0]              rsh, rdiff;
	logic                     ge;
	logic [34:0]              q_next;

	function automatic logic [63:0] abs65(input logic signed [64:0] a);
		logic [64:0] n;
		n = -a;
		return a[64] ? n[63:0] : a[63:0];
	endfunction

	// sign and magnitude to saturated 32-bit two's complement
	function automatic logic [31:0] sat_sm(input logic neg, input logic [63:0] m);
		logic [31:0] r;
		if (!neg) begin
			r = (m > 64'h7FFFFFFF) ? 32'h7FFFFFFF : m[31:0];
		end else begin
			r = (m >= 64'h80000000) ? 32'h80000000 : (~m[31:0] + 32'd1);
		end
		return r;
	endfunction

	// round half away from zero at the fraction point
	function automatic logic [31:0] rnd(input logic signed [64:0] a);
		logic [63:0] t;
		t = abs65(a) + (64'd1 << (FRAC_BITS - 1));
		return sat_sm(a[64], t >> FRAC_BITS);
	endfunction

	// operand select for the product sequence
	always_comb begin
		opa = x_q.re;
		opb = y_q.re;
		case (k_q)
			3'd0: begin opa = y_q.re; opb = y_q.re; end
			3'd1: begin opa = y_q.im; opb = y_q.im; end
			3'd2: begin opa = x_q.re; opb = y_q.re; end
			3'd3: begin opa = x_q.im; opb = y_q.im; end
			3'd4: begin opa = x_q.im; opb = y_q.re; end
			3'd5: begin opa = x_q.re; opb = y_q.im; end
			default: begin opa = x_q.re; opb = y_q.re; end
		endcase
	end

	// accumulate step
	always_comb begin
		acc_sub = (k_q == 3'd3 && op_q == OP_MUL) || (k_q == 3'd5 && op_q == OP_DIV);
		case (k_q)
			3'd0, 3'd1: acc_n = acc_c_q;
			3'd2, 3'd3: acc_n = acc_a_q;
			default:    acc_n = acc_b_q;
		endcase
		acc_n = acc_sub ? acc_n - {prod_s1[63], prod_s1} : acc_n + {prod_s1[63], prod_s1};
	end

	// restoring division, one quotient bit a cycle
	always_comb begin
		rsh    = {rem_q, dvd_q[DIV_STEPS-1]};
		ge     = rsh >= {1'b0, acc_c_q[63:0]};
		rdiff  = ge ? rsh - {1'b0, acc_c_q[63:0]} : rsh;
		q_next = {q_q, ge};
		q_cap  = (q_next > {1'b0, QCAP}) ? QCAP : q_next[33:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
		end else begin
			unique case (state_q)
				A_IDLE: if (req.go) state_q <= A_MUL;
				A_MUL:  state_q <= A_ACC;
				A_ACC: begin
					if (k_q == 3'd5) begin
						state_q <= (op_q == OP_MUL) ? A_RND : A_DCHK;
					end else begin
						state_q <= A_MUL;
					end
				end
				A_RND:  state_q <= A_FIN;
				A_DCHK: state_q <= (acc_c_q == '0) ? A_FIN : A_DIV;
				A_DIV:  if (cnt_q == '0 && part_q) state_q <= A_FIN;
				A_FIN:  state_q <= A_IDLE;
				default: state_q <= A_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			A_IDLE: begin
				if (req.go) begin
					op_q    <= req.op;
					x_q     <= req.x;
					y_q     <= req.y;
					k_q     <= (req.op == OP_DIV) ? 3'd0 : 3'd2;
					acc_a_q <= '0;
					acc_b_q <= '0;
					acc_c_q <= '0;
					dz_q    <= 1'b0;
				end
			end
			A_MUL: prod_s1 <= opa * opb;
			A_ACC: begin
				case (k_q)
					3'd0, 3'd1: acc_c_q <= acc_n;
					3'd2, 3'd3: acc_a_q <= acc_n;
					default:    acc_b_q <= acc_n;
				endcase
				k_q <= k_q + 3'd1;
			end
			A_RND: begin
				z_q.re <= rnd(acc_a_q);
				z_q.im <= rnd(acc_b_q);
			end
			A_DCHK: begin
				if (acc_c_q == '0) begin
					z_q  <= '0;
					dz_q <= 1'b1;
				end else begin
					dvd_q  <= {abs65(acc_a_q), {FRAC_BITS{1'b0}}};
					rem_q  <= '0;
					q_q    <= '0;
					cnt_q  <= CNT_W'(DIV_STEPS - 1);
					part_q <= 1'b0;
				end
			end
			A_DIV: begin
				if (cnt_q == '0) begin
					if (!part_q) begin
						z_q.re <= sat_sm(acc_a_q[64], {30'd0, q_cap});
						dvd_q  <= {abs65(acc_b_q), {FRAC_BITS{1'b0}}};
						rem_q  <= '0;
						q_q    <= '0;
						cnt_q  <= CNT_W'(DIV_STEPS - 1);
						part_q <= 1'b1;
					end else begin
						z_q.im <= sat_sm(acc_b_q[64], {30'd0, q_cap});
					end
				end else begin
					dvd_q <= dvd_q << 1;
					rem_q <= rdiff[63:0];
					q_q   <= q_cap;
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign z         = z_q;
	assign stat.idle = (state_q == A_IDLE);
	assign stat.done = (state_q == A_FIN);
	assign stat.dz   = dz_q;

endmodule
`default_nettype wire

// File: hdl/complex_tridiagonal_solver_top.sv
`default_nettype none
// channel  | dir | payload                                         | marker
// s_*      | in  | sub, diag, super, rhs (re/im each), 256 bits    | tlast = last row
// m_*      | out | solution re/im, row index, 72 bits              | tlast = last entry,
//          |     |                                                 | tuser = zero pivot
// row 0 is stored directly; a later row takes one division and two products
// back substitution takes one division for the last row and one product and
// one division per earlier row, then reads out one solution entry at a time;
// the divider works one quotient bit a cycle
// s_tready is high only while the sequencer is idle
// output is held in a register until taken; m_tready low stalls the readout
// reset is asynchronous; the row stores need no clearing pass
module complex_tridiagonal_solver_top import cts_pkg::*; #(
	parameter int MAX_ROWS  = MAX_ROWS_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// sub_re, sub_im, diag_re, diag_im, super_re, super_im, rhs_re, rhs_im
	input  wire logic [255:0] s_tdata,
	input  wire logic         s_tlast,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// solution_re, solution_im, row_index, 2 zero bits
	output logic [71:0]       m_tdata,
	output logic              m_tlast,
	// zero_pivot
	output logic [0:0]        m_tuser
);

	localparam int AW = $clog2(MAX_ROWS);
	localparam int CW = $bits(cplx_t);

	typedef enum logic [12:0] {
		S_IDLE = 13'b0000000000001,
		S_FRD  = 13'b0000000000010,
		S_FLAT = 13'b0000000000100,
		S_FM   = 13'b0000000001000,
		S_FT1  = 13'b0000000010000,
		S_FT2  = 13'b0000000100000,
		S_FWR  = 13'b0000001000000,
		S_BX   = 13'b0000010000000,
		S_BRD  = 13'b0000100000000,
		S_BLAT = 13'b0001000000000,
		S_BM   = 13'b0010000000000,
		S_ORD  = 13'b0100000000000,
		S_OLD  = 13'b1000000000000
	} state_t;

	state_t          state_q;
	cplx_t           sub_q, dg_q, sup_q, rhs_q;
	cplx_t           rd_q, rh_q, s_q, h_q, d_q, m_q, x_q;
	logic            last_q, pivot_q;
	logic [AW-1:0]   row_q, k_q, o_q;
	logic            alu_go_q;
	op_t             alu_op_q;
	cplx_t           alu_x_q, alu_y_q;
	alu_req_t        alu_req;
	alu_stat_t       alu_stat;
	cplx_t           alu_z;
	logic            out_load, in_acc;
	logic            m_tvalid_q;
	cplx_t           out_sol_q;
	logic [ROW_W-1:0] out_row_q;
	logic            out_last_q, out_piv_q;
	logic            f_we, f_re, sol_we, sol_re;
	logic [AW-1:0]   f_raddr;
	logic [CW-1:0]   rdiag_rd, ssup_rd, rrhs_rd, sol_rd;

	function automatic logic [31:0] sat_sub(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] d;
		d = {a[31], a} - {b[31], b};
		if (d[32] != d[31]) begin
			return d[32] ? 32'h80000000 : 32'h7FFFFFFF;
		end
		return d[31:0];
	endfunction

	function automatic cplx_t csub(input cplx_t a, input cplx_t b);
		cplx_t r;
		r.re = sat_sub(a.re, b.re);
		r.im = sat_sub(a.im, b.im);
		return r;
	endfunction

	assign s_tready = (state_q == S_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_load = (state_q == S_OLD) && (!m_tvalid_q || m_tready);

	// request to the shared arithmetic unit
	assign alu_req = '{go: alu_go_q, op: alu_op_q, x: alu_x_q, y: alu_y_q};

	// row stores
	assign f_we    = (state_q == S_FWR);
	assign f_re    = (state_q == S_FRD) || (state_q == S_BRD);
	assign f_raddr = (state_q == S_FRD) ? row_q - AW'(1) : k_q;
	assign sol_we  = (state_q == S_BX) && alu_stat.done;
	assign sol_re  = (state_q == S_ORD);

	cts_ram #(.WIDTH(CW), .DEPTH(MAX_ROWS)) u_rdiag (
		.clk(clk), .we(f_we), .waddr(row_q), .wdata(rd_q),
		.re(f_re), .raddr(f_raddr), .rdata(rdiag_rd)
	);
	cts_ram #(.WIDTH(CW), .DEPTH(MAX_ROWS)) u_ssup (
		.clk(clk), .we(f_we), .waddr(row_q), .wdata(sup_q),
		.re(f_re), .raddr(f_raddr), .rdata(ssup_rd)
	);
	cts_ram #(.WIDTH(CW), .DEPTH(MAX_ROWS)) u_rrhs (
		.clk(clk), .we(f_we), .waddr(row_q), .wdata(rh_q),
		.re(f_re), .raddr(f_raddr), .rdata(rrhs_rd)
	);
	cts_ram #(.WIDTH(CW), .DEPTH(MAX_ROWS)) u_sol (
		.clk(clk), .we(sol_we), .waddr(k_q), .wdata(alu_z),
		.re(sol_re), .raddr(o_q), .rdata(sol_rd)
	);

	cts_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
		.clk(clk), .arst_n(arst_n), .req(alu_req), .z(alu_z), .stat(alu_stat)
	);

	// sequencer control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			row_q      <= '0;
			pivot_q    <= 1'b0;
			alu_go_q   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			// start after a fetch, the last row write or a chained step
			alu_go_q <= (state_q == S_FLAT) || (state_q == S_BLAT) ||
				((state_q == S_FWR) && last_q) ||
				(alu_stat.done && (state_q == S_FM || state_q == S_FT1 ||
					state_q == S_BM));
			m_tvalid_q <= out_load || (m_tvalid_q && !m_tready);
			if (alu_stat.done) begin
				pivot_q <= pivot_q | alu_stat.dz;
			end
			unique case (state_q)
				S_IDLE: if (in_acc) state_q <= (row_q == '0) ? S_FWR : S_FRD;
				S_FRD:  state_q <= S_FLAT;
				S_FLAT: state_q <= S_FM;
				S_FM:   if (alu_stat.done) state_q <= S_FT1;
				S_FT1:  if (alu_stat.done) state_q <= S_FT2;
				S_FT2:  if (alu_stat.done) state_q <= S_FWR;
				S_FWR: begin
					if (last_q) begin
						state_q <= S_BX;
					end else begin
						row_q   <= row_q + AW'(1);
						state_q <= S_IDLE;
					end
				end
				S_BX: if (alu_stat.done) state_q <= (k_q == '0) ? S_ORD : S_BRD;
				S_BRD:  state_q <= S_BLAT;
				S_BLAT: state_q <= S_BM;
				S_BM:   if (alu_stat.done) state_q <= S_BX;
				S_ORD:  state_q <= S_OLD;
				S_OLD: if (out_load) begin
					if (o_q == row_q) begin
						row_q   <= '0;
						pivot_q <= 1'b0;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_ORD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// working registers and arithmetic requests
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: if (in_acc) begin
				sub_q.re <= s_tdata[31:0];
				sub_q.im <= s_tdata[63:32];
				dg_q.re  <= s_tdata[95:64];
				dg_q.im  <= s_tdata[127:96];
				sup_q.re <= s_tdata[159:128];
				sup_q.im <= s_tdata[191:160];
				rhs_q.re <= s_tdata[223:192];
				rhs_q.im <= s_tdata[255:224];
				last_q   <= s_tlast || (row_q == AW'(MAX_ROWS - 1));
				rd_q.re  <= s_tdata[95:64];
				rd_q.im  <= s_tdata[127:96];
				rh_q.re  <= s_tdata[223:192];
				rh_q.im  <= s_tdata[255:224];
			end
			S_FLAT: begin
				s_q      <= ssup_rd;
				h_q      <= rrhs_rd;
				alu_op_q <= OP_DIV;
				alu_x_q  <= sub_q;
				alu_y_q  <= rdiag_rd;
			end
			S_FM: if (alu_stat.done) begin
				m_q      <= alu_z;
				alu_op_q <= OP_MUL;
				alu_x_q  <= alu_z;
				alu_y_q  <= s_q;
			end
			S_FT1: if (alu_stat.done) begin
				rd_q     <= csub(dg_q, alu_z);
				alu_op_q <= OP_MUL;
				alu_x_q  <= m_q;
				alu_y_q  <= h_q;
			end
			S_FT2: if (alu_stat.done) rh_q <= csub(rhs_q, alu_z);
			S_FWR: begin
				k_q      <= row_q;
				alu_op_q <= OP_DIV;
				alu_x_q  <= rh_q;
				alu_y_q  <= rd_q;
			end
			S_BX: if (alu_stat.done) begin
				x_q <= alu_z;
				o_q <= '0;
				if (k_q != '0) begin
					k_q <= k_q - AW'(1);
				end
			end
			S_BLAT: begin
				d_q      <= rdiag_rd;
				h_q      <= rrhs_rd;
				alu_op_q <= OP_MUL;
				alu_x_q  <= ssup_rd;
				alu_y_q  <= x_q;
			end
			S_BM: if (alu_stat.done) begin
				alu_op_q <= OP_DIV;
				alu_x_q  <= csub(h_q, alu_z);
				alu_y_q  <= d_q;
			end
			S_OLD: if (out_load) begin
				out_sol_q  <= sol_rd;
				out_row_q  <= ROW_W'(o_q);
				out_last_q <= (o_q == row_q);
				out_piv_q  <= pivot_q;
				o_q        <= o_q + AW'(1);
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = {2'b00, out_row_q, out_sol_q.im, out_sol_q.re};
	assign m_tlast    = out_last_q;
	assign m_tuser[0] = out_piv_q;

`ifndef SYNTH
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		alu_go_q |-> alu_stat.idle)
		else $error("arithmetic request while unit busy");
	a_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		alu_stat.done |-> (state_q == S_FM || state_q == S_FT1 || state_q == S_FT2 ||
			state_q == S_BX || state_q == S_BM))
		else $error("arithmetic result with no waiting step");
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> alu_stat.idle)
		else $error("input ready while arithmetic unit busy");
	a_sys_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && o_q == row_q) |=> (row_q == '0 && !pivot_q && m_tvalid && m_tlast))
		else $error("system state not cleared after final entry");
`endif

endmodule
`default_nettype wire

// File: tb/tb.sv
import cts_pkg::*;

// one row of the system as it travels on the slave channel
typedef struct {
	cplx_t sub;
	cplx_t dg;
	cplx_t sup;
	cplx_t rhs;
} row_t;

// one solution entry as it travels on the master channel
typedef struct {
	logic signed [31:0] re;
	logic signed [31:0] im;
	logic [5:0]         idx;
	logic               last;
	logic               zp;
} sol_t;

class thomas_scoreboard;
	localparam int NROWS = MAX_ROWS_DEF;
	localparam int FB    = FRAC_BITS_DEF;

	cplx_t elim_diag [NROWS];
	cplx_t upper     [NROWS];
	cplx_t elim_rhs  [NROWS];
	cplx_t x_vec     [NROWS];
	int    rows_in_sys;
	bit    pivot_hit;
	sol_t  pending_sol [$];
	int    mismatches;
	int    entries_ok;
	int    systems;
	int    pivot_systems;

	function new();
		rows_in_sys   = 0;
		pivot_hit     = 0;
		mismatches    = 0;
		entries_ok    = 0;
		systems       = 0;
		pivot_systems = 0;
	endfunction

	function logic signed [31:0] clip32(logic signed [127:0] v);
		if (v > 128'sd2147483647) return 32'sh7fffffff;
		if (v < -128'sd2147483648) return 32'sh80000000;
		return v[31:0];
	endfunction

	// exact product, each part rounded half away from zero
	function logic signed [31:0] round_sum(logic signed [127:0] s);
		logic signed [127:0] mag;
		mag = (s < 0) ? -s : s;
		mag = (mag + (128'sd1 <<< (FB - 1))) >>> FB;
		return (s < 0) ? clip32(-mag) : clip32(mag);
	endfunction

	function cplx_t cmult(cplx_t a, cplx_t b);
		logic signed [127:0] ar, ai, br, bi;
		cplx_t r;
		ar = a.re; ai = a.im; br = b.re; bi = b.im;
		r.re = round_sum(ar * br - ai * bi);
		r.im = round_sum(ar * bi + ai * br);
		return r;
	endfunction

	function cplx_t csubt(cplx_t a, cplx_t b);
		logic signed [127:0] ar, ai, br, bi;
		cplx_t r;
		ar = a.re; ai = a.im; br = b.re; bi = b.im;
		r.re = clip32(ar - br);
		r.im = clip32(ai - bi);
		return r;
	endfunction

	function logic signed [31:0] quot(logic signed [127:0] num, logic signed [127:0] den);
		logic signed [127:0] mag;
		mag = (num < 0) ? -num : num;
		mag = (mag <<< FB) / den;
		return (num < 0) ? clip32(-mag) : clip32(mag);
	endfunction

	// zero divisor yields zero and flags the system
	function cplx_t cdivide(cplx_t n, cplx_t d);
		logic signed [127:0] nr, ni, dr, di, den;
		cplx_t r;
		nr = n.re; ni = n.im; dr = d.re; di = d.im;
		den = dr * dr + di * di;
		r.re = '0;
		r.im = '0;
		if (den == 0) begin
			pivot_hit = 1;
			return r;
		end
		r.re = quot(nr * dr + ni * di, den);
		r.im = quot(ni * dr - nr * di, den);
		return r;
	endfunction

	// forward elimination per accepted row, back substitution on the last one
	function void note_row(row_t row, bit last_in);
		int    r;
		bit    last;
		cplx_t m;
		sol_t  s;
		r    = rows_in_sys;
		last = last_in || (r + 1 >= NROWS);
		if (r == 0) begin
			elim_diag[0] = row.dg;
			elim_rhs[0]  = row.rhs;
		end else begin
			m            = cdivide(row.sub, elim_diag[r-1]);
			elim_diag[r] = csubt(row.dg, cmult(m, upper[r-1]));
			elim_rhs[r]  = csubt(row.rhs, cmult(m, elim_rhs[r-1]));
		end
		upper[r] = row.sup;
		if (!last) begin
			rows_in_sys = r + 1;
			return;
		end
		x_vec[r] = cdivide(elim_rhs[r], elim_diag[r]);
		for (int i = r - 1; i >= 0; i--)
			x_vec[i] = cdivide(csubt(elim_rhs[i], cmult(upper[i], x_vec[i+1])), elim_diag[i]);
		for (int k = 0; k <= r; k++) begin
			s.re   = x_vec[k].re;
			s.im   = x_vec[k].im;
			s.idx  = k[5:0];
			s.last = (k == r);
			s.zp   = pivot_hit;
			pending_sol.push_back(s);
		end
		systems++;
		if (pivot_hit) pivot_systems++;
		rows_in_sys = 0;
		pivot_hit   = 0;
	endfunction

	function void check_entry(sol_t got);
		sol_t exp_s;
		if (pending_sol.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected solution entry: row %0d re %0d im %0d",
					got.idx, got.re, got.im);
			return;
		end
		exp_s = pending_sol.pop_front();
		if (got.re !== exp_s.re || got.im !== exp_s.im || got.idx !== exp_s.idx ||
				got.last !== exp_s.last || got.zp !== exp_s.zp) begin
			mismatches++;
			if (mismatches <= 10)
				$display({"mismatch row %0d: exp re %0d im %0d idx %0d last %0b zp %0b",
					" | got re %0d im %0d idx %0d last %0b zp %0b"},
					exp_s.idx, exp_s.re, exp_s.im, exp_s.idx, exp_s.last, exp_s.zp,
					got.re, got.im, got.idx, got.last, got.zp);
		end else begin
			entries_ok++;
		end
	endfunction
endclass

module tb;
	localparam int IDLE_LIMIT = 60000;
	localparam int TARGET     = 270;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [255:0] s_tdata;
	logic         s_tlast;
	logic         m_tvalid;
	logic         m_tready;
	logic [71:0]  m_tdata;
	logic         m_tlast;
	logic [0:0]   m_tuser;

	thomas_scoreboard sb;
	int  rows_sent;
	int  idle_cycles;
	int  out_stall;
	bit  no_gaps;
	row_t rw;

	complex_tridiagonal_solver_top u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tlast (s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.m_tuser (m_tuser)
	);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// transaction monitors and idle watchdog
	always @(posedge clk) begin
		sol_t  got;
		row_t  seen;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				seen.sub.re = s_tdata[31:0];    seen.sub.im = s_tdata[63:32];
				seen.dg.re  = s_tdata[95:64];   seen.dg.im  = s_tdata[127:96];
				seen.sup.re = s_tdata[159:128]; seen.sup.im = s_tdata[191:160];
				seen.rhs.re = s_tdata[223:192]; seen.rhs.im = s_tdata[255:224];
				sb.note_row(seen, s_tlast);
			end
			if (m_tvalid && m_tready) begin
				got.re   = m_tdata[31:0];
				got.im   = m_tdata[63:32];
				got.idx  = m_tdata[69:64];
				got.last = m_tlast;
				got.zp   = m_tuser[0];
				sb.check_entry(got);
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end
		end
	end

	// receiver stalls drawn per solution entry
	always @(posedge clk) begin
		int w;
		if (!arst_n) begin
			m_tready  <= 0;
			out_stall <= 0;
		end else if (out_stall > 0) begin
			m_tready  <= 0;
			out_stall <= out_stall - 1;
		end else if (m_tvalid && m_tready && !no_gaps) begin
			w = $urandom_range(0, 15);
			if (w == 0) begin
				m_tready <= 1;
			end else begin
				m_tready  <= 0;
				out_stall <= w - 1;
			end
		end else begin
			m_tready <= 1;
		end
	end

	// one row transaction, preceded by a random gap unless no_gaps is set
	task automatic send_row(row_t r, bit last);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			s_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1;
		s_tlast  <= last;
		s_tdata  <= {r.rhs.im, r.rhs.re, r.sup.im, r.sup.re,
			r.dg.im, r.dg.re, r.sub.im, r.sub.re};
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
		rows_sent++;
	endtask

	function automatic logic signed [31:0] pick(int mode, int lo_mag, int hi_mag);
		logic signed [31:0] v;
		case (mode)
			0: v = $urandom;
			1: v = 32'sh7fffffff;
			2: v = 32'sh80000000;
			3: v = 0;
			default: begin
				v = $urandom_range(hi_mag, lo_mag);
				if ($urandom_range(0, 1)) v = -v;
			end
		endcase
		return v;
	endfunction

	// well-conditioned row: dominant diagonal, modest off-diagonals
	function automatic row_t calm_row();
		row_t r;
		r.sub.re = pick(4, 0, 1 << 24);        r.sub.im = pick(4, 0, 1 << 24);
		r.dg.re  = pick(4, 2 << 24, 5 << 24);  r.dg.im  = pick(4, 0, 2 << 24);
		r.sup.re = pick(4, 0, 1 << 24);        r.sup.im = pick(4, 0, 1 << 24);
		r.rhs.re = pick(4, 0, 16 << 24);       r.rhs.im = pick(4, 0, 16 << 24);
		return r;
	endfunction

	function automatic row_t fill_row(int mode);
		row_t r;
		r.sub.re = pick(mode, 0, 1); r.sub.im = pick(mode, 0, 1);
		r.dg.re  = pick(mode, 0, 1); r.dg.im  = pick(mode, 0, 1);
		r.sup.re = pick(mode, 0, 1); r.sup.im = pick(mode, 0, 1);
		r.rhs.re = pick(mode, 0, 1); r.rhs.im = pick(mode, 0, 1);
		return r;
	endfunction

	initial begin
		int len;
		int kind;
		sb          = new();
		rows_sent   = 0;
		idle_cycles = 0;
		no_gaps     = 0;
		arst_n      = 0;
		s_tvalid    = 0;
		s_tdata     = '0;
		s_tlast     = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: single-row systems at the extremes and with a zero pivot
		send_row(fill_row(1), 1);
		send_row(fill_row(2), 1);
		send_row(fill_row(3), 1);
		// all-maximum and all-minimum rows in one system
		send_row(fill_row(1), 0);
		send_row(fill_row(2), 0);
		send_row(fill_row(1), 1);
		// well-formed system
		for (int i = 0; i < 5; i++) send_row(calm_row(), i == 4);
		// zero diagonal mid-system
		for (int i = 0; i < 4; i++) begin
			rw = calm_row();
			if (i == 1) begin
				rw.dg.re = 0;
				rw.dg.im = 0;
			end
			send_row(rw, i == 3);
		end
		// zero row zero, then minimum values, then a random row
		send_row(fill_row(3), 0);
		send_row(fill_row(2), 0);
		send_row(fill_row(0), 1);

		// random systems: mostly short and well formed, some noise
		while (rows_sent < TARGET) begin
			kind = $urandom_range(0, 19);
			no_gaps = ($urandom_range(0, 5) == 0);
			if (rows_sent > 100 && rows_sent < 170 && kind == 0) begin
				// full-length system, last row forced by size
				for (int i = 0; i < MAX_ROWS_DEF; i++) send_row(calm_row(), 0);
			end else begin
				len = $urandom_range(1, 8);
				for (int i = 0; i < len; i++) begin
					if (kind < 12) rw = calm_row();
					else if (kind < 17) rw = fill_row(0);
					else begin
						rw = calm_row();
						if ($urandom_range(0, 2) == 0) begin
							rw.dg.re = 0;
							rw.dg.im = 0;
						end
					end
					send_row(rw, i == len - 1);
				end
			end
		end
		s_tvalid <= 0;
		s_tlast  <= 0;
		no_gaps  = 0;
		// let the monitor note the final row before draining
		@(posedge clk);

		// drain, then a quiet window for stray entries
		while (sb.pending_sol.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);

		$display("rows sent %0d in %0d systems (%0d with zero pivot), entries checked %0d",
			rows_sent, sb.systems, sb.pivot_systems, sb.entries_ok + sb.mismatches);
		$display("mismatches %0d, entries still expected %0d",
			sb.mismatches, sb.pending_sol.size());
		if (sb.mismatches == 0 && sb.pending_sol.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

// File: files.f
hdl/cts_pkg.sv
hdl/cts_ram.sv
hdl/cts_alu.sv
hdl/complex_tridiagonal_solver_top.sv
tb/tb.sv
